/* rtl/bitmap_first_fit_allocator_macros.svh */
// Assertion macros for the allocator
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg)
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/bffa_pkg.sv */
package bffa_pkg;
  localparam int MAP_WORDS = 32;
  localparam int TABLE_SLOTS = 16;
  localparam int MAP_AW = $clog2(MAP_WORDS);
  localparam int MAP_CW = $clog2(MAP_WORDS + 1);
  localparam int CLU_W = MAP_AW + 5;
  localparam int NEED_W = CLU_W + 1;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int SLOT_CW = $clog2(TABLE_SLOTS + 1);
  localparam int CB_W = 17;
  localparam int PROD_W = CLU_W + CB_W;
  localparam logic [33:0] MAP_CLUSTERS = 34'(MAP_WORDS * 32);

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL = 3'd1;
  localparam logic [2:0] ST_NO_RUN = 3'd2;
  localparam logic [2:0] ST_BEYOND_END = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [2:0] REG_HEAP_BASE = 3'd0;
  localparam logic [2:0] REG_HEAP_END = 3'd1;
  localparam logic [2:0] REG_CLUSTER_BYTES = 3'd2;
  localparam logic [2:0] REG_MAP_WORDS = 3'd3;
  localparam logic [2:0] REG_TABLE_SLOTS = 3'd4;

  typedef struct packed {
    logic found;
    logic [4:0] hit_bit;
    logic [NEED_W-1:0] cnt_out;
  } scan_res_t;
endpackage

/* rtl/bitmap_first_fit_allocator.sv */
// Allocate: divider, then a bitmap scan of up to MAP_WORDS words, then marking of the run
// words (bitmap scan one word per cycle, marking one word per cycle).
// Release: table lookup over up to TABLE_SLOTS slots, a setup step, then marking per run word.
// Rejects found at accept return done the next cycle; busy drops with done, so the
// next transaction can start in the done cycle. done cannot be stalled.
// Synchronous reset frees every cluster and slot and loads register defaults.
module bitmap_first_fit_allocator (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic operation,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_address,
  output logic done,
  output logic [31:0] granted_address,
  output logic [2:0] status,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
`include "bitmap_first_fit_allocator_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SCAN, S_MUL, S_CHECK, S_MARK_PRE, S_MARK, S_FIND
  } state_t;

  state_t state;
  logic [31:0] heap_base, heap_end;
  logic [16:0] cluster_bytes;
  logic [5:0] map_words_in_use;
  logic [4:0] table_slots_in_use;

  logic [31:0] size_q, rel_q, addr_q;
  logic [bffa_pkg::NEED_W-1:0] need, cnt;
  logic [bffa_pkg::CLU_W-1:0] begin_q, run_start, run_end;
  logic [bffa_pkg::MAP_AW-1:0] scan_word, mark_word;
  logic [bffa_pkg::PROD_W-1:0] product;
  logic [bffa_pkg::SLOT_W-1:0] slot_sel;
  logic [bffa_pkg::SLOT_CW-1:0] find_k;
  logic set_used;

  logic slot_valid [bffa_pkg::TABLE_SLOTS];
  logic [31:0] slot_address [bffa_pkg::TABLE_SLOTS];
  logic [bffa_pkg::CLU_W-1:0] slot_start [bffa_pkg::TABLE_SLOTS];
  logic [bffa_pkg::NEED_W-1:0] slot_length [bffa_pkg::TABLE_SLOTS];

  logic [16:0] cb_eff;
  logic [bffa_pkg::MAP_CW-1:0] words_eff;
  logic [bffa_pkg::SLOT_CW-1:0] active;
  logic have_slot;
  logic [bffa_pkg::SLOT_W-1:0] free_slot;
  logic [33:0] addr_sum;
  logic [31:0] mark_mask;
  logic [bffa_pkg::CLU_W-1:0] hit_begin;

  logic map_we;
  logic [bffa_pkg::MAP_AW-1:0] map_raddr;
  logic [31:0] map_rdata, map_wdata;
  logic div_start, div_done;
  logic [32:0] quotient;
  bffa_pkg::scan_res_t scan_res;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign busy = state != S_IDLE;
  assign cb_eff = (cluster_bytes == 17'd0) ? 17'd1 : cluster_bytes;
  assign words_eff = (map_words_in_use > 6'(bffa_pkg::MAP_WORDS))
                     ? bffa_pkg::MAP_CW'(bffa_pkg::MAP_WORDS)
                     : bffa_pkg::MAP_CW'(map_words_in_use);
  assign active = (table_slots_in_use > 5'(bffa_pkg::TABLE_SLOTS))
                  ? bffa_pkg::SLOT_CW'(bffa_pkg::TABLE_SLOTS)
                  : bffa_pkg::SLOT_CW'(table_slots_in_use);

  always_comb begin
    have_slot = 1'b0;
    free_slot = '0;
    for (int s = bffa_pkg::TABLE_SLOTS - 1; s >= 0; s--) begin
      if (bffa_pkg::SLOT_CW'(s) < active && !slot_valid[s]) begin
        have_slot = 1'b1;
        free_slot = bffa_pkg::SLOT_W'(s);
      end
    end
  end

  always_comb begin
    case (paddr[4:2])
      bffa_pkg::REG_HEAP_BASE: prdata = heap_base;
      bffa_pkg::REG_HEAP_END: prdata = heap_end;
      bffa_pkg::REG_CLUSTER_BYTES: prdata = {15'd0, cluster_bytes};
      bffa_pkg::REG_MAP_WORDS: prdata = {26'd0, map_words_in_use};
      bffa_pkg::REG_TABLE_SLOTS: prdata = {27'd0, table_slots_in_use};
      default: prdata = 32'h0;
    endcase
  end

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      mark_mask[b] = ({mark_word, 5'(b)} >= run_start) && ({mark_word, 5'(b)} <= run_end);
    end
  end

  assign map_wdata = set_used ? (map_rdata | mark_mask) : (map_rdata & ~mark_mask);
  assign map_we = state == S_MARK;
  assign hit_begin = bffa_pkg::CLU_W'({1'b0, scan_word, scan_res.hit_bit}
                     + bffa_pkg::NEED_W'(1) - need);
  assign addr_sum = {2'b0, heap_base} + 34'(product) + {2'b0, size_q};
  assign div_start = start && !busy && !operation;

  always_comb begin
    case (state)
      S_SCAN: map_raddr = scan_word + bffa_pkg::MAP_AW'(1);
      S_MARK_PRE: map_raddr = run_start[bffa_pkg::CLU_W-1:5];
      S_MARK: map_raddr = mark_word + bffa_pkg::MAP_AW'(1);
      default: map_raddr = '0;
    endcase
  end

  bffa_map_ram u_map (
    .clk(clk), .rst(rst), .we(map_we), .waddr(mark_word), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  bffa_div u_div (
    .clk(clk), .rst(rst), .div_start(div_start),
    .numerator({1'b0, request_bytes} + {16'd0, cb_eff} - 33'd1),
    .divisor(cb_eff), .div_done(div_done), .quotient(quotient)
  );

  bffa_run_scan u_scan (.word(map_rdata), .cnt_in(cnt), .need(need), .res(scan_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= 32'h0;
      heap_end <= 32'd65536;
      cluster_bytes <= 17'd64;
      map_words_in_use <= 6'd32;
      table_slots_in_use <= 5'd16;
    end else if (cfg_we) begin
      case (paddr[4:2])
        bffa_pkg::REG_HEAP_BASE: heap_base <= pwdata;
        bffa_pkg::REG_HEAP_END: heap_end <= pwdata;
        bffa_pkg::REG_CLUSTER_BYTES: cluster_bytes <= pwdata[16:0];
        bffa_pkg::REG_MAP_WORDS: map_words_in_use <= pwdata[5:0];
        bffa_pkg::REG_TABLE_SLOTS: table_slots_in_use <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      granted_address <= 32'h0;
      status <= bffa_pkg::ST_OK;
      for (int s = 0; s < bffa_pkg::TABLE_SLOTS; s++) begin
        slot_valid[s] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            size_q <= request_bytes;
            rel_q <= release_address;
            slot_sel <= free_slot;
            granted_address <= 32'h0;
            addr_q <= 32'h0;
            if (operation) begin
              find_k <= '0;
              if (active == '0) begin
                status <= bffa_pkg::ST_UNKNOWN;
                done <= 1'b1;
              end else begin
                state <= S_FIND;
              end
            end else if (!have_slot) begin
              status <= bffa_pkg::ST_TABLE_FULL;
              done <= 1'b1;
            end else if (request_bytes == 32'h0 || words_eff == '0) begin
              status <= bffa_pkg::ST_NO_RUN;
              done <= 1'b1;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if ({1'b0, quotient} > bffa_pkg::MAP_CLUSTERS) begin
              status <= bffa_pkg::ST_NO_RUN;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              need <= quotient[bffa_pkg::NEED_W-1:0];
              cnt <= '0;
              scan_word <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_res.found) begin
            begin_q <= hit_begin;
            state <= S_MUL;
          end else if ({1'b0, scan_word} == words_eff - bffa_pkg::MAP_CW'(1)) begin
            status <= bffa_pkg::ST_NO_RUN;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= scan_res.cnt_out;
            scan_word <= scan_word + bffa_pkg::MAP_AW'(1);
          end
        end
        S_MUL: begin
          product <= begin_q * cb_eff;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (addr_sum > {2'b0, heap_end}) begin
            status <= bffa_pkg::ST_BEYOND_END;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            addr_q <= heap_base + 32'(product);
            slot_valid[slot_sel] <= 1'b1;
            slot_address[slot_sel] <= heap_base + 32'(product);
            slot_start[slot_sel] <= begin_q;
            slot_length[slot_sel] <= need;
            run_start <= begin_q;
            run_end <= begin_q + need[bffa_pkg::CLU_W-1:0] - bffa_pkg::CLU_W'(1);
            set_used <= 1'b1;
            state <= S_MARK_PRE;
          end
        end
        S_FIND: begin
          if (find_k == active) begin
            status <= bffa_pkg::ST_UNKNOWN;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (slot_valid[find_k[bffa_pkg::SLOT_W-1:0]]
                       && slot_address[find_k[bffa_pkg::SLOT_W-1:0]] == rel_q) begin
            slot_valid[find_k[bffa_pkg::SLOT_W-1:0]] <= 1'b0;
            run_start <= slot_start[find_k[bffa_pkg::SLOT_W-1:0]];
            run_end <= slot_start[find_k[bffa_pkg::SLOT_W-1:0]]
                       + slot_length[find_k[bffa_pkg::SLOT_W-1:0]][bffa_pkg::CLU_W-1:0]
                       - bffa_pkg::CLU_W'(1);
            set_used <= 1'b0;
            state <= S_MARK_PRE;
          end else begin
            find_k <= find_k + bffa_pkg::SLOT_CW'(1);
          end
        end
        S_MARK_PRE: begin
          mark_word <= run_start[bffa_pkg::CLU_W-1:5];
          state <= S_MARK;
        end
        S_MARK: begin
          if (mark_word == run_end[bffa_pkg::CLU_W-1:5]) begin
            status <= bffa_pkg::ST_OK;
            granted_address <= addr_q;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            mark_word <= mark_word + bffa_pkg::MAP_AW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done, "accepted transaction lost")
  `BFFA_ASSERT_NEXT(a_single_strobe, done && !start, !done, "result strobe longer than one cycle")
  `BFFA_ASSERT_SAME(a_fail_zero, done && status != bffa_pkg::ST_OK, granted_address == 32'h0,
                    "failed transaction returned an address")
endmodule

/* rtl/bffa_map_ram.sv */
module bffa_map_ram (
  input  logic clk,
  input  logic rst,
  input  logic we,
  input  logic [bffa_pkg::MAP_AW-1:0] waddr,
  input  logic [31:0] wdata,
  input  logic [bffa_pkg::MAP_AW-1:0] raddr,
  output logic [31:0] rdata
);
  logic [31:0] mem [bffa_pkg::MAP_WORDS];
  logic [bffa_pkg::MAP_WORDS-1:0] valid;
  logic [31:0] rd_q;
  logic rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rd_q : 32'h0;
endmodule

/* rtl/bffa_div.sv */
module bffa_div (
  input  logic clk,
  input  logic rst,
  input  logic div_start,
  input  logic [32:0] numerator,
  input  logic [bffa_pkg::CB_W-1:0] divisor,
  output logic div_done,
  output logic [32:0] quotient
);
  logic running;
  logic [5:0] count;
  logic [bffa_pkg::CB_W-1:0] rem;
  logic [bffa_pkg::CB_W:0] trial;
  logic ge;

  assign trial = {rem, quotient[32]};
  assign ge = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      div_done <= 1'b0;
      count <= '0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        quotient <= numerator;
        rem <= '0;
        count <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? bffa_pkg::CB_W'(trial - {1'b0, divisor}) : trial[bffa_pkg::CB_W-1:0];
        quotient <= {quotient[31:0], ge};
        count <= count + 6'd1;
        if (count == 6'd32) begin
          running <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/bffa_run_scan.sv */
module bffa_run_scan (
  input  logic [31:0] word,
  input  logic [bffa_pkg::NEED_W-1:0] cnt_in,
  input  logic [bffa_pkg::NEED_W-1:0] need,
  output bffa_pkg::scan_res_t res
);
  always_comb begin
    logic used_seen;
    logic [4:0] last;
    logic [bffa_pkg::NEED_W:0] len;
    res = '0;
    for (int b = 0; b < 32; b++) begin
      used_seen = 1'b0;
      last = '0;
      for (int j = 0; j < 32; j++) begin
        if (j <= b && word[j]) begin
          used_seen = 1'b1;
          last = 5'(j);
        end
      end
      len = used_seen ? (bffa_pkg::NEED_W+1)'(5'(b) - last)
                      : {1'b0, cnt_in} + (bffa_pkg::NEED_W+1)'(b + 1);
      if (!res.found && len >= {1'b0, need}) begin
        res.found = 1'b1;
        res.hit_bit = 5'(b);
      end
      if (b == 31) begin
        res.cnt_out = len[bffa_pkg::NEED_W-1:0];
      end
    end
  end
endmodule

/* sim/tb_checker.sv */
`timescale 1ns / 100ps

module tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        operation,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_address,
  input  logic        done,
  input  logic [31:0] granted_address,
  input  logic [2:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct {
    logic [31:0] addr;
    logic [2:0]  code;
  } grant_t;

  grant_t      expected_grants[$];

  bit [31:0]   heap_base_q, heap_end_q;
  bit [16:0]   cluster_q;
  bit [5:0]    words_q;
  bit [4:0]    slots_q;

  bit [31:0]   occ_map[bffa_pkg::MAP_WORDS];
  bit          slot_live[bffa_pkg::TABLE_SLOTS];
  bit [31:0]   slot_addr[bffa_pkg::TABLE_SLOTS];
  longint      slot_first[bffa_pkg::TABLE_SLOTS];
  longint      slot_len[bffa_pkg::TABLE_SLOTS];

  task automatic mark_run(longint first, longint len, bit used);
    longint c;
    for (longint k = 0; k < len; k++) begin
      c = first + k;
      if ((c >> 5) >= bffa_pkg::MAP_WORDS) break;
      occ_map[c >> 5][c & 31] = used;
    end
  endtask

  task automatic predict_grant(bit op, bit [31:0] want, bit [31:0] addr_in, output grant_t g);
    longint unsigned cb, need, run, base_addr;
    int nslots, nwords, slot, first;
    bit have_slot, found;
    g.addr = '0;
    nslots = (slots_q > bffa_pkg::TABLE_SLOTS) ? bffa_pkg::TABLE_SLOTS : slots_q;
    nwords = (words_q > bffa_pkg::MAP_WORDS) ? bffa_pkg::MAP_WORDS : words_q;
    if (op) begin
      g.code = bffa_pkg::ST_UNKNOWN;
      for (int s = 0; s < nslots; s++) begin
        if (slot_live[s] && slot_addr[s] == addr_in) begin
          mark_run(slot_first[s], slot_len[s], 1'b0);
          slot_live[s] = 1'b0;
          g.code = bffa_pkg::ST_OK;
          break;
        end
      end
      return;
    end
    cb = (cluster_q == 0) ? 1 : cluster_q;
    need = (longint'(want) + cb - 1) / cb;
    have_slot = 1'b0;
    slot = 0;
    for (int s = 0; s < nslots; s++) begin
      if (!slot_live[s]) begin
        slot = s;
        have_slot = 1'b1;
        break;
      end
    end
    if (!have_slot) begin
      g.code = bffa_pkg::ST_TABLE_FULL;
      return;
    end
    if (need == 0) begin
      g.code = bffa_pkg::ST_NO_RUN;
      return;
    end
    found = 1'b0;
    run = 0;
    first = 0;
    for (int i = 0; i < nwords * 32; i++) begin
      if (occ_map[i >> 5][i & 31]) begin
        run = 0;
      end else begin
        if (run == 0) first = i;
        run++;
        if (run == need) begin
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) begin
      g.code = bffa_pkg::ST_NO_RUN;
      return;
    end
    base_addr = longint'(heap_base_q) + longint'(first) * cb;
    if (base_addr + longint'(want) > longint'(heap_end_q)) begin
      g.code = bffa_pkg::ST_BEYOND_END;
      return;
    end
    mark_run(first, need, 1'b1);
    slot_live[slot] = 1'b1;
    slot_addr[slot] = base_addr[31:0];
    slot_first[slot] = first;
    slot_len[slot] = need;
    g.addr = base_addr[31:0];
    g.code = bffa_pkg::ST_OK;
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      heap_base_q <= '0;
      heap_end_q <= 32'd65536;
      cluster_q <= 17'd64;
      words_q <= 6'd32;
      slots_q <= 5'd16;
      for (int w = 0; w < bffa_pkg::MAP_WORDS; w++) occ_map[w] = '0;
      for (int s = 0; s < bffa_pkg::TABLE_SLOTS; s++) slot_live[s] = 1'b0;
      expected_grants.delete();
      pending <= 0;
    end else begin
      if (done) begin
        checked <= checked + 1;
        if (expected_grants.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result addr=%h status=%0d",
                                    granted_address, status);
        end else begin
          g = expected_grants.pop_front();
          if (g.addr !== granted_address || g.code !== status) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                       g.addr, g.code, granted_address, status);
          end
        end
      end
      if (start && !busy) begin
        predict_grant(operation, request_bytes, release_address, g);
        expected_grants.push_back(g);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          bffa_pkg::REG_HEAP_BASE:     heap_base_q <= pwdata;
          bffa_pkg::REG_HEAP_END:      heap_end_q <= pwdata;
          bffa_pkg::REG_CLUSTER_BYTES: cluster_q <= pwdata[16:0];
          bffa_pkg::REG_MAP_WORDS:     words_q <= pwdata[5:0];
          bffa_pkg::REG_TABLE_SLOTS:   slots_q <= pwdata[4:0];
          default: ;
        endcase
      end
      pending <= expected_grants.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = 1'b0;
  logic [31:0] request_bytes = '0;
  logic [31:0] release_address = '0;
  logic        done;
  logic [31:0] granted_address;
  logic [2:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, checked;
  int cycles = 0;
  int settings = 0;
  bit calm = 1'b0;
  logic [31:0] live_addrs[$];
  bit          op_fifo[$];
  logic [31:0] cur_cluster = 32'd64;

  always #10 clk = ~clk;

  bitmap_first_fit_allocator DUT (.*);

  tb_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL bitmap_first_fit_allocator");
      $finish;
    end
  end

  // track live grants so releases mostly hit
  always @(posedge clk) begin
    bit op;
    if (!rst) begin
      if (done && op_fifo.size() > 0) begin
        op = op_fifo.pop_front();
        if (!op && status == bffa_pkg::ST_OK) live_addrs.push_back(granted_address);
      end
      if (start && !busy) op_fifo.push_back(operation);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || op_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic issue(bit op, logic [31:0] bytes, logic [31:0] addr);
    operation <= op;
    request_bytes <= bytes;
    release_address <= addr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (!calm && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic setup(logic [31:0] base, logic [31:0] hend, logic [31:0] cb,
                       logic [31:0] words, logic [31:0] slots);
    drain();
    reg_write(bffa_pkg::REG_HEAP_BASE, base);
    reg_write(bffa_pkg::REG_HEAP_END, hend);
    reg_write(bffa_pkg::REG_CLUSTER_BYTES, cb);
    reg_write(bffa_pkg::REG_MAP_WORDS, words);
    reg_write(bffa_pkg::REG_TABLE_SLOTS, slots);
    cur_cluster = (cb[16:0] == 0) ? 32'd1 : {15'd0, cb[16:0]};
    live_addrs.delete();
    settings++;
  endtask

  task automatic random_items(int n);
    int k;
    int r;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        r = $urandom_range(99);
        if (r < 80) a = $urandom_range(1, cur_cluster * 40);
        else if (r < 88) a = 0;
        else if (r < 94) a = $urandom();
        else a = cur_cluster * 32 * $urandom_range(1, 8);
        issue(1'b0, a, $urandom());
      end else if (r < 85 && live_addrs.size() > 0) begin
        k = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        issue(1'b1, $urandom(), a);
      end else begin
        issue(1'b1, $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    issue(1'b0, 32'd0, 32'd0);
    issue(1'b0, 32'd1, 32'd0);
    issue(1'b0, 32'd64, 32'd0);
    issue(1'b0, 32'd65, 32'd0);
    issue(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(1'b0, 32'd4096, 32'd0);
    issue(1'b1, 32'd0, 32'h1234_5678);
    issue(1'b1, 32'hFFFF_FFFF, 32'd64);
    issue(1'b0, 32'd65536, 32'd0);
    for (int i = 0; i < 14; i++) issue(1'b0, 32'd100, 32'd0);

    setup(32'hFFFF_F000, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
    issue(1'b0, 32'd32, 32'd0);
    issue(1'b0, 32'd1, 32'd0);
    random_items(150);

    setup(32'h0000_1000, 32'h0000_3000, 32'd0, 32'd2, 32'd4);
    random_items(200);

    setup(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h1FFFF, 32'd63, 32'd31);
    random_items(150);

    setup(32'd0, 32'd65536, 32'd16, 32'd0, 32'd8);
    random_items(60);

    setup(32'd0, 32'd65536, 32'd16, 32'd8, 32'd0);
    random_items(60);

    setup(32'h8000_0000, 32'h8000_8000, 32'd8, 32'd4, 32'd16);
    calm = 1'b1;
    random_items(300);
    calm = 1'b0;

    setup(32'h0, 32'hFFFF_FFFF, 32'd64, 32'd32, 32'd16);
    random_items(450);

    setup(32'h0, 32'd2000, 32'd4, 32'd16, 32'd12);
    random_items(350);

    drain();
    repeat (150) @(posedge clk);
    $display("covered %0d transactions over %0d register settings,", checked, settings + 1);
    $display("allocate and release with table, run and heap-end limits");
    if (errors == 0) begin
      $display("PASS bitmap_first_fit_allocator");
    end else begin
      $display("FAIL bitmap_first_fit_allocator");
    end
    $finish;
  end

endmodule
